[sv/can_encoder_feedback_unwrap_defines.svh]
// assertion helpers for the checker file
`ifndef CAN_ENCODER_FEEDBACK_UNWRAP_DEFINES_SVH
`define CAN_ENCODER_FEEDBACK_UNWRAP_DEFINES_SVH

// same-cycle implication
`define CEU_ASSERT_IMPL(lbl, clk, dis, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CEU_ASSERT_NEXT(lbl, clk, dis, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/ceu_pkg.sv]
`default_nettype none
package ceu_pkg;

    localparam int unsigned NUM_MOTORS_DEF = 4;

    localparam int unsigned IN_TDATA_W  = 48;
    localparam int unsigned IN_TUSER_W  = 2;
    localparam int unsigned OUT_TDATA_W = 96;
    localparam int unsigned CFG_ADDR_W  = 2;
    localparam int unsigned CFG_DATA_W  = 15;

    localparam logic [10:0] FIRST_MOTOR_ID_RST  = 11'd513;
    localparam logic [14:0] WRAP_THRESHOLD_RST  = 15'd7000;
    localparam logic [14:0] COUNTS_PER_TURN_RST = 15'd8191;

    localparam logic [3:0] DLC_FEEDBACK = 4'd8;

    localparam logic signed [39:0] POS_MAX = {1'b0, {39{1'b1}}};
    localparam logic signed [39:0] POS_MIN = {1'b1, {39{1'b0}}};

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_FIRST_MOTOR_ID  = 2'd0,
        CFG_WRAP_THRESHOLD  = 2'd1,
        CFG_COUNTS_PER_TURN = 2'd2
    } t_cfg_reg;

endpackage
`default_nettype wire

[sv/can_encoder_feedback_unwrap.sv]
// pipeline: an accepted transaction goes to the input register, its result to the output register
// throughput: one frame per cycle while the output is not stalled, also back to back on the
//   same motor; the per-motor angle and position registers are read and written in the same cycle
// rejected frames give no result and leave all state untouched
// reset (synchronous, active low) clears both stages, all motor state to zero and
//   loads the configuration defaults
`default_nettype none
module can_encoder_feedback_unwrap
    import ceu_pkg::*;
#(
    parameter int unsigned NumMotors = NUM_MOTORS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // data_length[3:0], frame_ident[14:4], angle_word[30:15], speed_word[46:31], zero
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // extended_id[0], remote_frame[1]
    input  wire logic [IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // motor_index[1:0], angle_now[17:2], velocity_now[33:18], angle_step[51:34],
    // position_counts[91:52], zero
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

    localparam int unsigned MotorIdxW = (NumMotors > 1) ? $clog2(NumMotors) : 1;

    logic [10:0] r_first_id;
    logic [14:0] r_wrap_thr;
    logic [14:0] r_cpt;

    logic                  r_in_valid, n_in_valid;
    logic [IN_TDATA_W-1:0] r_in_tdata;
    logic [IN_TUSER_W-1:0] r_in_tuser;

    logic signed [15:0] r_last_angle [NumMotors];
    logic signed [39:0] r_pos_sum    [NumMotors];

    logic                   r_out_valid, n_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_tdata, n_out_tdata;

    logic               in_ext, in_rtr;
    logic [3:0]         in_dlc;
    logic [10:0]        in_ident;
    logic signed [15:0] in_angle, in_speed;

    logic [11:0]          id_diff;
    logic                 in_window, frame_ok;
    logic [MotorIdxW-1:0] motor_sel;

    logic signed [15:0] old_angle;
    logic signed [39:0] old_pos;
    logic signed [16:0] raw_diff;
    logic signed [17:0] raw_step, thr_pos, thr_neg, cpt_ext;
    logic signed [17:0] n_step;
    logic signed [40:0] pos_sum;
    logic signed [39:0] n_pos;

    logic in_advance, in_fire, do_update;

    assign in_ext   = r_in_tuser[0];
    assign in_rtr   = r_in_tuser[1];
    assign in_dlc   = r_in_tdata[3:0];
    assign in_ident = r_in_tdata[14:4];
    assign in_angle = r_in_tdata[30:15];
    assign in_speed = r_in_tdata[46:31];

    // motor window, no wrap past the top of the identifier range
    assign id_diff   = {1'b0, in_ident} - {1'b0, r_first_id};
    assign in_window = !id_diff[11] && (id_diff[10:0] < 11'(NumMotors));
    assign frame_ok  = !in_ext && !in_rtr && (in_dlc == DLC_FEEDBACK) && in_window;
    assign motor_sel = id_diff[MotorIdxW-1:0];

    assign old_angle = r_last_angle[motor_sel];
    assign old_pos   = r_pos_sum[motor_sel];

    assign raw_diff = {in_angle[15], in_angle} - {old_angle[15], old_angle};
    assign raw_step = {raw_diff[16], raw_diff};
    assign thr_pos  = signed'({3'b000, r_wrap_thr});
    assign thr_neg  = -thr_pos;
    assign cpt_ext  = signed'({3'b000, r_cpt});

    always_comb begin
        if (raw_step > thr_pos) begin
            n_step = raw_step - cpt_ext;
        end else if (raw_step < thr_neg) begin
            n_step = raw_step + cpt_ext;
        end else begin
            n_step = raw_step;
        end
    end

    // saturating position update
    assign pos_sum = {old_pos[39], old_pos} + {{23{n_step[17]}}, n_step};

    always_comb begin
        if (pos_sum[40] != pos_sum[39]) begin
            n_pos = pos_sum[40] ? POS_MIN : POS_MAX;
        end else begin
            n_pos = pos_sum[39:0];
        end
    end

    // a rejected frame leaves without needing the output slot
    assign in_advance    = !r_out_valid || m_axis_tready || !frame_ok;
    assign s_axis_tready = !r_in_valid || in_advance;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign do_update     = r_in_valid && frame_ok && in_advance;

    always_comb begin
        if (in_fire) begin
            n_in_valid = 1'b1;
        end else if (in_advance) begin
            n_in_valid = 1'b0;
        end else begin
            n_in_valid = r_in_valid;
        end
    end

    always_comb begin
        n_out_tdata = r_out_tdata;
        if (do_update) begin
            n_out_valid = 1'b1;
            n_out_tdata = {4'b0000, n_pos, n_step, in_speed, in_angle, id_diff[1:0]};
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_id <= FIRST_MOTOR_ID_RST;
            r_wrap_thr <= WRAP_THRESHOLD_RST;
            r_cpt      <= COUNTS_PER_TURN_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_addr))
                CFG_FIRST_MOTOR_ID:  r_first_id <= i_cfg_wdata[10:0];
                CFG_WRAP_THRESHOLD:  r_wrap_thr <= i_cfg_wdata;
                CFG_COUNTS_PER_TURN: r_cpt      <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_tdata <= s_axis_tdata;
            r_in_tuser <= s_axis_tuser;
        end
        r_out_tdata <= n_out_tdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NumMotors; i++) begin
                r_last_angle[i] <= '0;
                r_pos_sum[i]    <= '0;
            end
        end else if (do_update) begin
            r_last_angle[motor_sel] <= in_angle;
            r_pos_sum[motor_sel]    <= n_pos;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_tdata;

endmodule
`default_nettype wire

[sv/ceu_checker.sv]
`default_nettype none
`include "can_encoder_feedback_unwrap_defines.svh"
module ceu_checker
    import ceu_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   s_axis_tvalid,
    input wire logic                   s_axis_tready,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // a stalled result holds
    `CEU_ASSERT_NEXT(a_out_hold, i_clk, !i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

    // a fresh result comes from an earlier input transaction
    `CEU_ASSERT_IMPL(a_out_origin, i_clk, !i_rst_n, $rose(m_axis_tvalid),
        $past(s_axis_tvalid && s_axis_tready, 2), "result without input transaction")

    // an empty output slot never blocks the input side
    `CEU_ASSERT_IMPL(a_ready_free, i_clk, !i_rst_n, !m_axis_tvalid,
        s_axis_tready, "input stalled with empty output")

    `CEU_ASSERT_NEXT(a_reset_clear, i_clk, 1'b0, !i_rst_n,
        !m_axis_tvalid, "result valid after reset")

endmodule

bind can_encoder_feedback_unwrap ceu_checker u_ceu_checker (.*);
`default_nettype wire
